// File: src/pfx_pkg.sv
`timescale 1ns / 1ps

package pfx_pkg;

    localparam int DATA_W = 16;
    localparam int SYM_W  = 8;
    localparam int STAT_W = 2;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_UNDERFLOW = 2'd1;
    localparam status_t ST_DIV_ZERO  = 2'd2;
    localparam status_t ST_OVERFLOW  = 2'd3;

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;

    // keep only the first error of an expression
    function automatic status_t note_error(status_t cur, status_t code);
        note_error = (cur == ST_OK) ? code : cur;
    endfunction

endpackage

// File: src/pfx_if.sv
`timescale 1ns / 1ps

interface pfx_in_if;
    import pfx_pkg::*;
    logic              valid;
    logic              ready;
    logic [SYM_W-1:0]  symbol;
    logic              end_of_expression;

    modport source (output valid, symbol, end_of_expression, input ready);
    modport sink   (input valid, symbol, end_of_expression, output ready);
endinterface

interface pfx_out_if;
    import pfx_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic [STAT_W-1:0]        status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// File: src/pfx_divider.sv
`timescale 1ns / 1ps

module pfx_divider
    import pfx_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t dividend,
    input  word_t divisor,
    output logic  busy,
    output logic  done,
    output word_t quotient
);

    localparam int IW = $clog2(DATA_W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [IW-1:0] iter_reg, iter_next;
    word_t         rem_reg, rem_next;
    word_t         quo_reg, quo_next;
    word_t         dvs_reg, dvs_next;
    logic [DATA_W:0] rem_shift;
    logic [DATA_W:0] diff;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DATA_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = IW'(DATA_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            iter_next = iter_reg - 1'b1;
            if (iter_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/pfx_stack.sv
`timescale 1ns / 1ps

module pfx_stack
    import pfx_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  word_t                    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output word_t                    rd_data
);

    word_t mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/postfix_expression_evaluator_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Interface   Payload
// expr     in   pfx_in_if   symbol[7:0], end_of_expression
// result   out  pfx_out_if  value[15:0] signed, status[1:0]
//
// Digit: IDLE, then PUSH. Operator: IDLE, POP_R, POP_L, EXEC, PUSH. '/' with non-zero divisor
// also waits in DIV for the 16-step divider. Last item adds TOP, the top read, and EMIT.
// Stack pops and the top read go through the single registered read port.
// rst_n clears the sequencer, stack count, error and output valid; stack contents are not reset.
// A finished result waits in the output register; only the next emit stalls on it.

module postfix_expression_evaluator_core
    import pfx_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    pfx_in_if.sink           expr,
    pfx_out_if.source        result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_POP_R = 8'b0000_0010,
        S_POP_L = 8'b0000_0100,
        S_EXEC  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_PUSH  = 8'b0010_0000,
        S_TOP   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             last_reg, last_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    status_t          err_reg, err_next;
    logic             rd_ok_reg, rd_ok_next;
    word_t            right_reg, right_next;
    word_t            push_reg, push_next;
    logic             neg_reg, neg_next;
    logic             out_valid_reg, out_valid_next;
    word_t            out_value_reg, out_value_next;
    status_t          out_status_reg, out_status_next;

    logic [CW-1:0]    cnt_m1;
    logic             emit_fire;
    word_t            left;
    word_t            l_mag, r_mag;
    word_t            prod;

    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    word_t            rd_data;
    logic             div_start, div_busy, div_done;
    word_t            quotient;

    pfx_stack #(.DEPTH(STACK_DEPTH)) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pfx_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (l_mag),
        .divisor  (r_mag),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign cnt_m1  = cnt_reg - 1'b1;
    assign rd_addr = cnt_m1[AW-1:0];
    assign wr_addr = cnt_reg[AW-1:0];
    assign left    = rd_ok_reg ? rd_data : '0;
    assign l_mag   = left[DATA_W-1] ? word_t'(-left) : left;
    assign r_mag   = right_reg[DATA_W-1] ? word_t'(-right_reg) : right_reg;
    assign prod    = word_t'(left * right_reg);

    always_comb
    begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        rd_ok_next      = rd_ok_reg;
        right_next      = right_reg;
        push_next       = push_reg;
        neg_next        = neg_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        div_start       = 1'b0;
        emit_fire       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (expr.valid)
                begin
                    sym_next  = expr.symbol;
                    last_next = expr.end_of_expression;
                    if (expr.symbol >= CH_ZERO && expr.symbol <= CH_NINE)
                    begin
                        push_next  = word_t'(expr.symbol - CH_ZERO);
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_POP_R;
                    end
                end
            end
            S_POP_R, S_POP_L:
            begin
                if (state_reg == S_POP_L)
                begin
                    right_next = rd_ok_reg ? rd_data : '0;
                end
                if (cnt_reg != '0)
                begin
                    rd_en      = 1'b1;
                    cnt_next   = cnt_m1;
                    rd_ok_next = 1'b1;
                end
                else
                begin
                    rd_ok_next = 1'b0;
                    err_next   = note_error(err_reg, ST_UNDERFLOW);
                end
                state_next = (state_reg == S_POP_R) ? S_POP_L : S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_PUSH;
                case (sym_reg)
                    CH_PLUS:  push_next = left + right_reg;
                    CH_MINUS: push_next = left - right_reg;
                    CH_MUL:   push_next = prod;
                    CH_DIV:
                    begin
                        if (right_reg == '0)
                        begin
                            push_next = '0;
                            err_next  = note_error(err_reg, ST_DIV_ZERO);
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            neg_next   = left[DATA_W-1] ^ right_reg[DATA_W-1];
                            state_next = S_DIV;
                        end
                    end
                    default:  push_next = '0;
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    push_next  = neg_reg ? word_t'(-quotient) : quotient;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (cnt_reg == CW'(STACK_DEPTH))
                begin
                    err_next = note_error(err_reg, ST_OVERFLOW);
                end
                else
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = last_reg ? S_TOP : S_IDLE;
            end
            S_TOP:
            begin
                if (cnt_reg != '0)
                begin
                    rd_en      = 1'b1;
                    rd_ok_next = 1'b1;
                end
                else
                begin
                    rd_ok_next = 1'b0;
                    err_next   = note_error(err_reg, ST_UNDERFLOW);
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    emit_fire       = 1'b1;
                    out_valid_next  = 1'b1;
                    out_value_next  = rd_ok_reg ? rd_data : '0;
                    out_status_next = err_reg;
                    cnt_next        = '0;
                    err_next        = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            err_reg       <= err_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        last_reg       <= last_next;
        right_reg      <= right_next;
        push_reg       <= push_next;
        neg_reg        <= neg_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign expr.ready    = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.value  = out_value_reg;
    assign result.status = out_status_reg;

`ifndef SYNTHESIS
    a_div_only_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == S_DIV)
        else $error("divider busy outside divide state");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (cnt_reg == '0 && err_reg == ST_OK && out_valid_reg))
        else $error("stack or error not cleared after result");
`endif

endmodule
